// ===== hw/rtl/clause_satisfaction_tracker_unit_defines.svh =====
// assertion macros for the clause satisfaction tracker
// no dependencies
`ifndef CLAUSE_SATISFACTION_TRACKER_UNIT_DEFINES_SVH
`define CLAUSE_SATISFACTION_TRACKER_UNIT_DEFINES_SVH
// clocked property check with async reset disable
`define CST_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error("cst check failed");
// a stalled transaction keeps valid high and its payload steady
`define CST_ASSERT_HOLD(lbl, clk, rstn, vld, rdy, sig) \
  `CST_ASSERT(lbl, clk, rstn, (vld) && !(rdy) |=> (vld) && $stable(sig))
`endif

// ===== hw/rtl/cst_pkg.sv =====
// shared constants and types for the clause satisfaction tracker
// no dependencies
package cst_pkg;
  localparam int unsigned Atoms = 256;
  localparam int unsigned Clauses = 256;
  localparam int unsigned Literals = 1024;
  localparam int unsigned AtomW = 8;
  localparam int unsigned ClauseW = 8;
  localparam int unsigned LitW = 10;
  localparam int unsigned LitCntW = 11;
  localparam int unsigned CntW = 11;
  localparam int unsigned TotW = 9;

  localparam logic [1:0] OpAdd = 2'd0;
  localparam logic [1:0] OpMark = 2'd1;
  localparam logic [1:0] OpClear = 2'd2;
endpackage

// ===== hw/rtl/clause_satisfaction_tracker_unit.sv =====
// clause satisfaction tracker, top level
// depends on cst_pkg and clause_satisfaction_tracker_unit_defines.svh
`include "clause_satisfaction_tracker_unit_defines.svh"

// One transaction in, one transaction out. Literals live in a 1024-entry
// literal memory, per-clause satisfying counts in a 256-entry count memory
// and the atom assignments in a 256-entry assignment memory, all synchronous
// with registered reads. After reset a clearing pass over all 256 entries
// zeroes the count memory and the assignment memory, during which no input
// is taken. The assignment entry of the offered atom is read while the block
// waits in idle, so it is ready in the decode cycle after acceptance.
// A query, a same-value assign or a clear of an unassigned atom goes from
// decode straight to output; an add first reads the clause count and, unless
// a table is full, writes the new count and stores the literal. An assign or
// clear that changes the assignment walks the whole literal table once per
// direction of change (a change of value runs two passes). The walk is paced
// by the single port of the count memory: each matching literal costs a read
// and a write-back. The block returns to idle before taking the next input.
// The result waits in an output register, so the next input is taken and
// worked on while it waits; only when a finished result finds the register
// still full does the block stall.
module clause_satisfaction_tracker_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // operation[1:0], atom[9:2], polarity[10], end_of_clause[11], zeros
  input  logic [15:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // status[0], atom_assigned[1], atom_true[2], clauses_held[11:3],
  // unsolved_clauses[20:12], zeros
  output logic [23:0] m_axis_tdata_o
);

  localparam logic [3:0] StClr   = 4'd0;
  localparam logic [3:0] StIdle  = 4'd1;
  localparam logic [3:0] StAddRd = 4'd2;
  localparam logic [3:0] StAddWr = 4'd3;
  localparam logic [3:0] StScan  = 4'd4;
  localparam logic [3:0] StLitRd = 4'd5;
  localparam logic [3:0] StCntRd = 4'd6;
  localparam logic [3:0] StCntWr = 4'd7;
  localparam logic [3:0] StDone  = 4'd8;
  localparam logic [3:0] StOut   = 4'd9;
  localparam logic [3:0] StDec   = 4'd10;

  logic [3:0] state_q, state_d;

  // atom assignment memory: {flag, value}, cleared by the sweep
  logic [1:0] asg_mem [cst_pkg::Atoms];
  logic [1:0] asg_rd_q;

  // literal memory: {clause, sign, atom}
  logic [cst_pkg::ClauseW+cst_pkg::AtomW:0] lit_mem [cst_pkg::Literals];
  logic [cst_pkg::ClauseW+cst_pkg::AtomW:0] lit_rd_q;
  logic [cst_pkg::CntW-1:0] cnt_mem [cst_pkg::Clauses];
  logic [cst_pkg::CntW-1:0] cnt_rd_q;

  logic [cst_pkg::LitCntW-1:0] lit_tot_q;
  logic [cst_pkg::TotW-1:0]    cls_tot_q, unsolved_q;
  logic                        open_q;

  // current transaction
  logic [1:0]                op_q;
  logic [cst_pkg::AtomW-1:0] atom_q;
  logic                      pol_q, last_q;
  logic                      raise_q;     // pass direction
  logic                      value_q2;    // sign being walked
  logic                      second_q;    // a raise pass follows
  logic [cst_pkg::LitCntW-1:0] idx_q;     // also sweep counter
  logic                      status_q;
  logic                      cur_flag_q;  // addressed atom after this step
  logic                      cur_val_q;

  logic                      out_v_q;
  logic [23:0]               out_q;

  // memory control
  logic                            lit_we, lit_re, cnt_we, asg_we;
  logic [cst_pkg::LitW-1:0]        lit_ra;
  logic [cst_pkg::ClauseW-1:0]     cnt_addr;
  logic [cst_pkg::CntW-1:0]        cnt_wd;
  logic [cst_pkg::AtomW-1:0]       asg_addr;
  logic [1:0]                      asg_wd;

  logic in_fire;
  assign in_fire = s_axis_tvalid_i & s_axis_tready_o;
  assign s_axis_tready_o = (state_q == StIdle);
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_q;

  // the output register is free or is emptied at this edge
  logic out_load;
  assign out_load = (state_q == StOut) & (~out_v_q | m_axis_tready_i);

  logic [cst_pkg::ClauseW-1:0] lit_cls;
  logic                        lit_sgn;
  logic [cst_pkg::AtomW-1:0]   lit_atm;
  assign {lit_cls, lit_sgn, lit_atm} = lit_rd_q;

  logic add_full;
  assign add_full = (lit_tot_q >= cst_pkg::LitCntW'(cst_pkg::Literals)) |
                    (cls_tot_q >= cst_pkg::TotW'(cst_pkg::Clauses));

  logic lit_match;
  assign lit_match = (lit_atm == atom_q) & (lit_sgn == value_q2);

  logic [cst_pkg::ClauseW-1:0] open_c;
  assign open_c = cls_tot_q[cst_pkg::ClauseW-1:0];

  // decode-cycle view of the addressed atom's entry
  logic mark_chg, clear_hit;
  assign mark_chg  = (op_q == cst_pkg::OpMark) &
                     ~(asg_rd_q[1] & (asg_rd_q[0] == pol_q));
  assign clear_hit = (op_q == cst_pkg::OpClear) & asg_rd_q[1];

  always_comb begin
    state_d  = state_q;
    lit_we   = 1'b0;
    lit_re   = 1'b0;
    cnt_we   = 1'b0;
    asg_we   = 1'b0;
    lit_ra   = idx_q[cst_pkg::LitW-1:0];
    cnt_addr = open_c;
    cnt_wd   = cnt_rd_q;
    asg_addr = atom_q;
    asg_wd   = 2'b00;
    case (state_q)
      StClr: begin
        cnt_we   = 1'b1;
        cnt_addr = idx_q[cst_pkg::ClauseW-1:0];
        cnt_wd   = '0;
        asg_we   = 1'b1;
        asg_addr = idx_q[cst_pkg::AtomW-1:0];
        if (idx_q == cst_pkg::LitCntW'(cst_pkg::Clauses - 1)) state_d = StIdle;
      end
      StIdle: begin
        // fetch the offered atom's assignment ahead of decode
        asg_addr = s_axis_tdata_i[9:2];
        if (in_fire) state_d = StDec;
      end
      StDec: begin
        case (op_q)
          cst_pkg::OpAdd: state_d = StAddRd;
          cst_pkg::OpMark: begin
            if (mark_chg) begin
              asg_we  = 1'b1;
              asg_wd  = {1'b1, pol_q};
              state_d = StScan;
            end else begin
              state_d = StOut;
            end
          end
          cst_pkg::OpClear: begin
            if (clear_hit) begin
              asg_we  = 1'b1;
              state_d = StScan;
            end else begin
              state_d = StOut;
            end
          end
          default: state_d = StOut;
        endcase
      end
      StAddRd: begin
        // fresh clause starts at zero; otherwise read its count
        state_d = add_full ? StOut : StAddWr;
      end
      StAddWr: begin
        cnt_we = 1'b1;
        cnt_wd = (open_q ? cnt_rd_q : '0) +
                 cst_pkg::CntW'(cur_flag_q & (cur_val_q == pol_q));
        lit_we = 1'b1;
        state_d = StOut;
      end
      StScan: begin
        lit_re  = 1'b1;
        state_d = (idx_q >= lit_tot_q) ? StDone : StLitRd;
      end
      StLitRd: begin
        state_d = lit_match ? StCntRd : StScan;
        cnt_addr = lit_cls;
      end
      StCntRd: begin
        cnt_addr = lit_cls;
        state_d = StCntWr;
      end
      StCntWr: begin
        cnt_addr = lit_cls;
        cnt_we = 1'b1;
        if (raise_q) cnt_wd = (&cnt_rd_q) ? cnt_rd_q : cnt_rd_q + 1'b1;
        else         cnt_wd = (cnt_rd_q == '0) ? cnt_rd_q : cnt_rd_q - 1'b1;
        state_d = StScan;
      end
      StDone: begin
        state_d = second_q ? StScan : StOut;
      end
      StOut: begin
        state_d = out_load ? StIdle : StOut;
      end
      default: state_d = StIdle;
    endcase
  end

  // synchronous memories
  always_ff @(posedge clk_i) begin
    if (lit_we) lit_mem[lit_tot_q[cst_pkg::LitW-1:0]] <= {open_c, pol_q, atom_q};
    if (lit_re) lit_rd_q <= lit_mem[lit_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_addr] <= cnt_wd;
    cnt_rd_q <= cnt_mem[cnt_addr];
  end

  always_ff @(posedge clk_i) begin
    if (asg_we) asg_mem[asg_addr] <= asg_wd;
    asg_rd_q <= asg_mem[asg_addr];
  end

  // count value after the write in StAddWr, for closing a clause
  logic [cst_pkg::CntW-1:0] add_cnt;
  assign add_cnt = cnt_wd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StClr;
      lit_tot_q  <= '0;
      cls_tot_q  <= '0;
      unsolved_q <= '0;
      open_q     <= 1'b0;
      idx_q      <= '0;
      out_v_q    <= 1'b0;
      status_q   <= 1'b0;
      raise_q    <= 1'b0;
      second_q   <= 1'b0;
      value_q2   <= 1'b0;
      op_q       <= '0;
      atom_q     <= '0;
      pol_q      <= 1'b0;
      last_q     <= 1'b0;
      cur_flag_q <= 1'b0;
      cur_val_q  <= 1'b0;
      out_q      <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_v_q <= 1'b1;
        out_q   <= {3'b000, unsolved_q, cls_tot_q,
                    cur_flag_q & cur_val_q, cur_flag_q, status_q};
      end else if (m_axis_tready_i) begin
        out_v_q <= 1'b0;
      end
      case (state_q)
        StClr: idx_q <= idx_q + 1'b1;
        StIdle: begin
          idx_q    <= '0;
          status_q <= 1'b0;
          if (in_fire) begin
            op_q   <= s_axis_tdata_i[1:0];
            atom_q <= s_axis_tdata_i[9:2];
            pol_q  <= s_axis_tdata_i[10];
            last_q <= s_axis_tdata_i[11];
          end
        end
        StDec: begin
          if (mark_chg) begin
            cur_flag_q <= 1'b1;
            cur_val_q  <= pol_q;
          end else if (clear_hit) begin
            cur_flag_q <= 1'b0;
            cur_val_q  <= 1'b0;
          end else begin
            cur_flag_q <= asg_rd_q[1];
            cur_val_q  <= asg_rd_q[0];
          end
          if (asg_rd_q[1]) begin
            // an existing assignment is withdrawn first
            raise_q  <= 1'b0;
            value_q2 <= asg_rd_q[0];
            second_q <= (op_q == cst_pkg::OpMark);
          end else begin
            raise_q  <= 1'b1;
            value_q2 <= pol_q;
            second_q <= 1'b0;
          end
        end
        StAddRd: if (add_full) status_q <= 1'b1;
        StAddWr: begin
          lit_tot_q <= lit_tot_q + 1'b1;
          if (last_q) begin
            open_q    <= 1'b0;
            cls_tot_q <= cls_tot_q + 1'b1;
            if (add_cnt == '0) unsolved_q <= unsolved_q + 1'b1;
          end else begin
            open_q <= 1'b1;
          end
        end
        StScan: if (idx_q < lit_tot_q) idx_q <= idx_q + 1'b1;
        StCntWr: begin
          if ({1'b0, lit_cls} < cls_tot_q) begin
            if (raise_q && cnt_rd_q == '0 && !(&cnt_rd_q) && unsolved_q != '0)
              unsolved_q <= unsolved_q - 1'b1;
            if (!raise_q && cnt_rd_q == cst_pkg::CntW'(1))
              unsolved_q <= unsolved_q + 1'b1;
          end
        end
        StDone: begin
          idx_q    <= '0;
          raise_q  <= 1'b1;
          value_q2 <= pol_q;
          second_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  `CST_ASSERT(a_ready_idle, clk_i, rst_ni, s_axis_tready_o |-> (state_q == StIdle))
  `CST_ASSERT(a_unsolved_bound, clk_i, rst_ni, unsolved_q <= cls_tot_q)
  `CST_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_fire |=> !s_axis_tready_o)
  `CST_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o, m_axis_tready_i, m_axis_tdata_o)

endmodule

// ===== bench/testbench.sv =====
// self-checking bench for clause_satisfaction_tracker_unit: literal loads, atom marks and clears
// depends on cst_pkg and the rtl of clause_satisfaction_tracker_unit
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // operation code that the block answers without changing anything
  localparam logic [1:0] OpQuery = 2'd3;
  localparam int unsigned QuietLimit = 20000;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] atom;
    logic       pol;
    logic       eoc;
    logic       drain;  // sender waits for all answers before offering this one
  } cmd_t;

  // packed from the top bit down, so status lands in bit 0
  typedef struct packed {
    logic [8:0] unsolved;
    logic [8:0] clauses;
    logic       is_true;
    logic       assigned;
    logic       status;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;

  clause_satisfaction_tracker_unit u_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o
  );

  always #1 clk_i = ~clk_i;

  cmd_t    pending_cmds[$];
  answer_t expected_answers[$];
  int      error_count = 0;
  int      sent_count = 0;
  int      answer_count = 0;
  int      quiet_cycles = 0;

  // tracker state mirrored in the bench
  bit          asg_flag[cst_pkg::Atoms];
  bit          asg_val[cst_pkg::Atoms];
  logic [7:0]  lit_atom[cst_pkg::Literals];
  bit          lit_sign[cst_pkg::Literals];
  int          lit_clause[cst_pkg::Literals];
  int          sat_count[cst_pkg::Clauses];
  int          clause_cnt = 0;
  int          lit_cnt = 0;
  bit          open_flag = 0;
  int          unsolved_cnt = 0;

  // walk every stored literal of the atom with the given sign
  function automatic void shift_counts(logic [7:0] a, bit v, bit up);
    int c;
    for (int i = 0; i < lit_cnt; i++) begin
      if (lit_atom[i] == a && lit_sign[i] == v) begin
        c = lit_clause[i];
        if (up) begin
          if (sat_count[c] == 0 && c < clause_cnt && unsolved_cnt > 0) unsolved_cnt--;
          sat_count[c]++;
        end else if (sat_count[c] > 0) begin
          sat_count[c]--;
          if (sat_count[c] == 0 && c < clause_cnt) unsolved_cnt++;
        end
      end
    end
  endfunction

  function automatic void unassign(logic [7:0] a);
    if (asg_flag[a]) begin
      shift_counts(a, asg_val[a], 1'b0);
      asg_flag[a] = 0;
      asg_val[a] = 0;
    end
  endfunction

  function automatic answer_t track_step(cmd_t cmd);
    answer_t ans;
    int c;
    ans = '0;
    case (cmd.op)
      cst_pkg::OpAdd: begin
        if (lit_cnt >= cst_pkg::Literals || clause_cnt >= cst_pkg::Clauses) begin
          ans.status = 1'b1;
        end else begin
          c = clause_cnt;
          if (!open_flag) begin
            sat_count[c] = 0;
            open_flag = 1;
          end
          lit_atom[lit_cnt] = cmd.atom;
          lit_sign[lit_cnt] = cmd.pol;
          lit_clause[lit_cnt] = c;
          lit_cnt++;
          // literal already satisfied by the current assignment
          if (asg_flag[cmd.atom] && asg_val[cmd.atom] == cmd.pol) sat_count[c]++;
          if (cmd.eoc) begin
            open_flag = 0;
            clause_cnt++;
            if (sat_count[c] == 0) unsolved_cnt++;
          end
        end
      end
      cst_pkg::OpMark: begin
        if (!(asg_flag[cmd.atom] && asg_val[cmd.atom] == cmd.pol)) begin
          unassign(cmd.atom);
          asg_flag[cmd.atom] = 1;
          asg_val[cmd.atom] = cmd.pol;
          shift_counts(cmd.atom, cmd.pol, 1'b1);
        end
      end
      cst_pkg::OpClear: unassign(cmd.atom);
      default: ;
    endcase
    ans.assigned = asg_flag[cmd.atom];
    ans.is_true = asg_flag[cmd.atom] & asg_val[cmd.atom];
    ans.clauses = clause_cnt[8:0];
    ans.unsolved = unsolved_cnt[8:0];
    return ans;
  endfunction

  // driver: one transaction per queued command, with random gaps between them in some stretches
  int  send_gap = 0;
  logic take_in;
  logic next_valid;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i <= '0;
    end else begin
      take_in = s_axis_tvalid_i && s_axis_tready_o;
      next_valid = s_axis_tvalid_i && !take_in;
      if (take_in) begin
        expected_answers.insert(expected_answers.size(),
                                track_step(pending_cmds.pop_front()));
        sent_count++;
        // idle stretches alternate with back-to-back stretches
        send_gap = ((sent_count / 64) % 2) ? $urandom_range(0, 16) : 0;
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_cmds.size() > 0 &&
                     !(pending_cmds[0].drain && expected_answers.size() != 0)) begin
          next_valid = 1'b1;
          s_axis_tdata_i <= {4'b0, pending_cmds[0].eoc, pending_cmds[0].pol,
                             pending_cmds[0].atom, pending_cmds[0].op};
        end
      end
      s_axis_tvalid_i <= next_valid;
    end
  end

  // monitor: checks each result transaction against the oldest prediction
  int      hold_cnt = 0;
  answer_t got;
  answer_t want;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = m_axis_tdata_o[20:0];
        if (expected_answers.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          error_count++;
        end else begin
          want = expected_answers.pop_front();
          if (got.status !== want.status)
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          if (got.assigned !== want.assigned)
            $display("%0t: atom_assigned expected %0d actual %0d", $time,
                     want.assigned, got.assigned);
          if (got.is_true !== want.is_true)
            $display("%0t: atom_true expected %0d actual %0d", $time,
                     want.is_true, got.is_true);
          if (got.clauses !== want.clauses)
            $display("%0t: clauses_held expected %0d actual %0d", $time,
                     want.clauses, got.clauses);
          if (got.unsolved !== want.unsolved)
            $display("%0t: unsolved_clauses expected %0d actual %0d", $time,
                     want.unsolved, got.unsolved);
          if (got !== want) error_count++;
        end
        answer_count++;
        // long hold-offs so the block backs up and stalls its input
        if (answer_count == 150 || answer_count == 520) hold_cnt = 400;
        else hold_cnt = ((answer_count / 48) % 2) ? $urandom_range(0, 16) : 0;
      end else if (hold_cnt > 0) begin
        hold_cnt--;
      end
      m_axis_tready_i <= (hold_cnt == 0);
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("clause_satisfaction_tracker_unit test failed");
      $finish;
    end
  end

  function automatic void queue_cmd(logic [1:0] op, logic [7:0] atom, logic pol,
                                    logic eoc, logic drain = 1'b0);
    cmd_t cmd;
    cmd.op = op;
    cmd.atom = atom;
    cmd.pol = pol;
    cmd.eoc = eoc;
    cmd.drain = drain;
    pending_cmds.insert(pending_cmds.size(), cmd);
  endfunction

  function automatic logic [7:0] pick_atom();
    return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 23));
  endfunction

  initial begin
    int made;
    int lits_est;
    int clauses_est;
    int len;
    int pick;
    // directed: query code, satisfied-at-load literal, open clause, same and opposite values
    queue_cmd(OpQuery, 8'd0, 1'b1, 1'b1);
    queue_cmd(cst_pkg::OpMark, 8'd0, 1'b1, 1'b0);
    queue_cmd(cst_pkg::OpAdd, 8'd0, 1'b1, 1'b1);
    queue_cmd(cst_pkg::OpAdd, 8'd255, 1'b0, 1'b0);
    queue_cmd(cst_pkg::OpAdd, 8'd7, 1'b1, 1'b1);
    queue_cmd(cst_pkg::OpMark, 8'd255, 1'b0, 1'b0);
    queue_cmd(cst_pkg::OpMark, 8'd255, 1'b0, 1'b1);
    queue_cmd(cst_pkg::OpMark, 8'd255, 1'b1, 1'b0);
    queue_cmd(cst_pkg::OpClear, 8'd255, 1'b0, 1'b0);
    queue_cmd(cst_pkg::OpClear, 8'd255, 1'b1, 1'b1);
    queue_cmd(cst_pkg::OpClear, 8'd200, 1'b0, 1'b0);
    queue_cmd(cst_pkg::OpMark, 8'd7, 1'b1, 1'b0);
    queue_cmd(cst_pkg::OpClear, 8'd7, 1'b0, 1'b0);
    queue_cmd(OpQuery, 8'd255, 1'b0, 1'b0);
    queue_cmd(cst_pkg::OpAdd, 8'd3, 1'b0, 1'b0);
    queue_cmd(cst_pkg::OpMark, 8'd3, 1'b0, 1'b0);
    queue_cmd(cst_pkg::OpAdd, 8'd4, 1'b1, 1'b1);
    queue_cmd(cst_pkg::OpMark, 8'd0, 1'b0, 1'b0);
    queue_cmd(OpQuery, 8'd3, 1'b1, 1'b0, 1'b1);
    lits_est = 6;
    clauses_est = 3;
    made = 0;
    // random: short clauses over a small atom pool, mixed with marks and clears
    while (made < 500) begin
      pick = $urandom_range(0, 9);
      if (pick < 3 && lits_est < 180) begin
        len = $urandom_range(1, 4);
        for (int k = 0; k < len; k++) begin
          // now and then a clause is left open and later adds extend it
          queue_cmd(cst_pkg::OpAdd, pick_atom(), 1'($urandom),
                    (k == len - 1) && ($urandom_range(0, 14) != 0));
          lits_est++;
          made++;
        end
        clauses_est++;
      end else begin
        queue_cmd(pick < 7 ? cst_pkg::OpMark : (pick < 9 ? cst_pkg::OpClear : OpQuery),
                  pick_atom(), 1'($urandom), 1'($urandom), made == 350);
        made++;
      end
    end
    // fill the clause table, then adds must be refused
    queue_cmd(cst_pkg::OpAdd, 8'd9, 1'b1, 1'b1);
    while (clauses_est < 300) begin
      queue_cmd(cst_pkg::OpAdd, pick_atom(), 1'($urandom), 1'b1);
      clauses_est++;
    end
    for (int k = 0; k < 8; k++)
      queue_cmd(k % 2 ? cst_pkg::OpClear : cst_pkg::OpMark, pick_atom(), 1'($urandom),
                1'($urandom));
    queue_cmd(cst_pkg::OpAdd, 8'd255, 1'b1, 1'b1);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_cmds.size() == 0 && !s_axis_tvalid_i && expected_answers.size() == 0);
    repeat (50) @(posedge clk_i);
    if (error_count == 0 && expected_answers.size() == 0)
      $display("clause_satisfaction_tracker_unit test passed");
    else
      $display("clause_satisfaction_tracker_unit test failed");
    $finish;
  end
endmodule
